// ===== hdl/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// pps_pkg: shared types, constants and functions of the path point store
// Holds request codes, field widths, the quarter-sine table and the rounding
// step that turns a radius-by-sine product into a coordinate offset.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int COORD_W        = 32;
  localparam int RAD_W          = 29;
  localparam int TOL_W          = 31;
  localparam int REQ_W          = 3;
  localparam int IDX_W          = 10;
  localparam int SINE_W         = 16;
  localparam int PROD_W         = RAD_W + 1 + SINE_W;
  localparam int POINT_DEPTH_D  = 1024;
  localparam int SUBPATH_DEPTH_D = 64;

  localparam logic [TOL_W-1:0] TOL_RESET = 31'd16384;

  localparam logic [REQ_W-1:0] REQ_MOVE   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_DRAW   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_CLOSE  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CIRCLE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_EMPTY  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_CURPT  = 3'd5;
  localparam logic [REQ_W-1:0] REQ_RDPT   = 3'd6;
  localparam logic [REQ_W-1:0] REQ_RDEND  = 3'd7;

  typedef logic signed [SINE_W-1:0] sine_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // Quarter wave of the sine, 0x4000 standing for one.
  function automatic logic [14:0] quarter_sine(input logic [6:0] a);
    logic [14:0] v;
    case (a)
      7'd0:  v = 15'h0000; 7'd1:  v = 15'h0192; 7'd2:  v = 15'h0324; 7'd3:  v = 15'h04b5;
      7'd4:  v = 15'h0646; 7'd5:  v = 15'h07d6; 7'd6:  v = 15'h0964; 7'd7:  v = 15'h0af1;
      7'd8:  v = 15'h0c7c; 7'd9:  v = 15'h0e06; 7'd10: v = 15'h0f8d; 7'd11: v = 15'h1112;
      7'd12: v = 15'h1294; 7'd13: v = 15'h1413; 7'd14: v = 15'h1590; 7'd15: v = 15'h1709;
      7'd16: v = 15'h187e; 7'd17: v = 15'h19ef; 7'd18: v = 15'h1b5d; 7'd19: v = 15'h1cc6;
      7'd20: v = 15'h1e2b; 7'd21: v = 15'h1f8c; 7'd22: v = 15'h20e7; 7'd23: v = 15'h223d;
      7'd24: v = 15'h238e; 7'd25: v = 15'h24da; 7'd26: v = 15'h2620; 7'd27: v = 15'h2760;
      7'd28: v = 15'h289a; 7'd29: v = 15'h29ce; 7'd30: v = 15'h2afb; 7'd31: v = 15'h2c21;
      7'd32: v = 15'h2d41; 7'd33: v = 15'h2e5a; 7'd34: v = 15'h2f6c; 7'd35: v = 15'h3076;
      7'd36: v = 15'h3179; 7'd37: v = 15'h3274; 7'd38: v = 15'h3368; 7'd39: v = 15'h3453;
      7'd40: v = 15'h3537; 7'd41: v = 15'h3612; 7'd42: v = 15'h36e5; 7'd43: v = 15'h37b0;
      7'd44: v = 15'h3871; 7'd45: v = 15'h392b; 7'd46: v = 15'h39db; 7'd47: v = 15'h3a82;
      7'd48: v = 15'h3b21; 7'd49: v = 15'h3bb6; 7'd50: v = 15'h3c42; 7'd51: v = 15'h3cc5;
      7'd52: v = 15'h3d3f; 7'd53: v = 15'h3daf; 7'd54: v = 15'h3e15; 7'd55: v = 15'h3e72;
      7'd56: v = 15'h3ec5; 7'd57: v = 15'h3f0f; 7'd58: v = 15'h3f4f; 7'd59: v = 15'h3f85;
      7'd60: v = 15'h3fb1; 7'd61: v = 15'h3fd4; 7'd62: v = 15'h3fec; 7'd63: v = 15'h3ffb;
      7'd64: v = 15'h4000;
      default: v = 15'h0000;
    endcase
    return v;
  endfunction

  // Full-turn sine over 256 steps, folded onto the quarter table.
  function automatic sine_t table_sine(input logic [7:0] e);
    logic [6:0]  a;
    logic [14:0] m;
    a = e[6] ? (7'h40 - {1'b0, e[5:0]}) : {1'b0, e[5:0]};
    m = quarter_sine(a);
    return e[7] ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  // Round half up and shift right by 14, flooring.
  function automatic logic [COORD_W-1:0] scale_off(input prod_t p);
    prod_t s;
    s = (p + PROD_W'(8192)) >>> 14;
    return s[COORD_W-1:0];
  endfunction

endpackage

// ===== hdl/pps_divider.sv =====
// ----------------------------------------------------------------------------
// pps_divider: restoring divider, one quotient bit per cycle
// Divides an unsigned dividend by an unsigned non-zero divisor.
// ----------------------------------------------------------------------------
module pps_divider
  import pps_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [TOL_W-1:0] dividend,
  input  logic [TOL_W-1:0] divisor,
  output logic [TOL_W-1:0] quotient,
  output logic             done
);

  localparam int CNT_W = $clog2(TOL_W + 1);

  logic [TOL_W-1:0] rem;
  logic [TOL_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [TOL_W:0]   trial;

  assign trial = {rem, quotient[TOL_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == CNT_W'(1));
      if (start) begin
        busy     <= 1'b1;
        cnt      <= CNT_W'(TOL_W);
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          rem      <= TOL_W'(trial - {1'b0, dvs});
          quotient <= {quotient[TOL_W-2:0], 1'b1};
        end else begin
          rem      <= trial[TOL_W-1:0];
          quotient <= {quotient[TOL_W-2:0], 1'b0};
        end
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== hdl/pps_scaler.sv =====
// ----------------------------------------------------------------------------
// pps_scaler: shared radius-by-sine multiplier
// Looks up the sine at a step and registers its product with the radius.
// ----------------------------------------------------------------------------
module pps_scaler
  import pps_pkg::*;
(
  input  logic             clk,
  input  logic [RAD_W-1:0] radius,
  input  logic [7:0]       step,
  output prod_t            prod
);

  sine_t t;

  assign t = table_sine(step);

  always_ff @(posedge clk) begin
    prod <= PROD_W'($signed({1'b0, radius}) * t);
  end

endmodule

// ===== hdl/path_point_store_with_circle.sv =====
// ----------------------------------------------------------------------------
// path_point_store_with_circle: vector path builder with on-chip point store
// Keeps 16.16 points and subpath end indices in on-chip memories and serves
// move, draw, close, circle, empty, current-point and read-back requests.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------------------
//   request  | req_valid / req_stall | req_type coord_x coord_y circle_radius
//            |                       | read_index
//   result   | res_valid / res_stall | status last_x last_y point_total
//            |                       | subpath_total read_px read_py read_end
//   config   | cfg_wen               | cfg_wdata (flatness tolerance)
//
// A circle first waits on the side-count division, then computes
// each emitted point on the shared multiplier, for up to 256 sides. Reset
// is synchronous; the memories need no clearing pass, as reads are bounded
// by the counts. A request is taken only while the sequencer is idle; a
// stalled result waits in the output register.
// ----------------------------------------------------------------------------
module path_point_store_with_circle
  import pps_pkg::*;
#(
  parameter int POINT_DEPTH   = POINT_DEPTH_D,
  parameter int SUBPATH_DEPTH = SUBPATH_DEPTH_D
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  logic [REQ_W-1:0]          req_type,
  input  logic signed [COORD_W-1:0] coord_x,
  input  logic signed [COORD_W-1:0] coord_y,
  input  logic [RAD_W-1:0]          circle_radius,
  input  logic [IDX_W-1:0]          read_index,
  output logic                      res_valid,
  input  logic                      res_stall,
  output logic                      status,
  output logic signed [COORD_W-1:0] last_x,
  output logic signed [COORD_W-1:0] last_y,
  output logic [10:0]               point_total,
  output logic [6:0]                subpath_total,
  output logic signed [COORD_W-1:0] read_px,
  output logic signed [COORD_W-1:0] read_py,
  output logic [10:0]               read_end,
  input  logic                      cfg_wen,
  input  logic [TOL_W-1:0]          cfg_wdata
);

  localparam int PCW = $clog2(POINT_DEPTH + 1);
  localparam int PAW = $clog2(POINT_DEPTH);
  localparam int SCW = $clog2(SUBPATH_DEPTH + 1);
  localparam int SAW = $clog2(SUBPATH_DEPTH);
  localparam int CW  = (PCW > IDX_W) ? PCW : IDX_W;
  localparam int SW  = (SCW > IDX_W) ? SCW : IDX_W;

  // Sequencer states.
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DECODE = 5'd1;
  localparam logic [4:0] S_MOVE   = 5'd2;
  localparam logic [4:0] S_DRAW   = 5'd3;
  localparam logic [4:0] S_CLOSE  = 5'd4;
  localparam logic [4:0] S_RLAST  = 5'd5;
  localparam logic [4:0] S_RLAST2 = 5'd6;
  localparam logic [4:0] S_RPT    = 5'd7;
  localparam logic [4:0] S_RPT2   = 5'd8;
  localparam logic [4:0] S_DIV    = 5'd9;
  localparam logic [4:0] S_CSET   = 5'd10;
  localparam logic [4:0] S_CMULX  = 5'd11;
  localparam logic [4:0] S_CMULY  = 5'd12;
  localparam logic [4:0] S_CPT    = 5'd13;
  localparam logic [4:0] S_CNEXT  = 5'd14;
  localparam logic [4:0] S_DONE   = 5'd15;

  // What follows a move or a draw: the result, or the next circle point.
  localparam logic CONT_DONE = 1'b0;
  localparam logic CONT_LOOP = 1'b1;

  logic [4:0]         state;
  logic               cont;
  logic [TOL_W-1:0]   tol;
  logic [REQ_W-1:0]   req;
  logic [RAD_W-1:0]   rad;
  logic [IDX_W-1:0]   idx;
  logic [COORD_W-1:0] px, py;
  logic [COORD_W-1:0] lx, ly;
  logic [COORD_W-1:0] cx, cy, dx;
  logic [PCW-1:0]     pc;
  logic [PCW-1:0]     start;
  logic [SCW-1:0]     sc;
  logic               dropped;
  logic [COORD_W-1:0] rpx, rpy;
  logic [PCW-1:0]     rend;
  logic [7:0]         i;
  logic [7:0]         nmask;
  logic [3:0]         sh;

  // Point memory and subpath end memory.
  logic [2*COORD_W-1:0] pmem [POINT_DEPTH];
  logic [PCW-1:0]       smem [SUBPATH_DEPTH];
  logic [2*COORD_W-1:0] pm_rdata;
  logic [PCW-1:0]       sm_rdata;
  logic                 pm_we, sm_we;
  logic [PAW-1:0]       pm_waddr, pm_raddr;

  logic           len_nz, len_one, dup, pfull, sfull;
  logic [PAW-1:0] last_pa;
  logic [PAW-1:0] idx_pa;
  logic [SAW-1:0] idx_sa;
  logic [4:0]     after_op;

  logic             div_start, div_done;
  logic [TOL_W-1:0] quo;
  logic [7:0]       step;
  prod_t            prod;
  logic [3:0]       n_c;

  assign len_nz  = pc != start;
  assign len_one = pc == PCW'(start + PCW'(1));
  assign dup     = len_nz && (lx == px) && (ly == py);
  assign pfull   = pc == PCW'(POINT_DEPTH);
  assign sfull   = sc == SCW'(SUBPATH_DEPTH);
  assign last_pa = PAW'(pc - PCW'(1));
  assign idx_pa  = PAW'(idx);
  assign idx_sa  = SAW'(idx);
  assign after_op = (cont == CONT_LOOP) ? S_CNEXT : S_DONE;

  assign pm_we    = (state == S_MOVE && len_one) || (state == S_DRAW && !dup && !pfull);
  assign pm_waddr = (state == S_MOVE) ? last_pa : PAW'(pc);
  assign pm_raddr = (state == S_RLAST) ? last_pa : idx_pa;
  assign sm_we    = ((state == S_MOVE && len_nz && !len_one) ||
                     (state == S_CLOSE && len_nz && !len_one)) && !sfull;

  always_ff @(posedge clk) begin
    if (pm_we) begin
      pmem[pm_waddr] <= {px, py};
    end
    pm_rdata <= pmem[pm_raddr];
  end

  always_ff @(posedge clk) begin
    if (sm_we) begin
      smem[SAW'(sc)] <= pc;
    end
    sm_rdata <= smem[idx_sa];
  end

  // Side count: the smallest power of two of at least four that covers it, at most 256; n_c holds its log2.
  always_comb begin
    if (quo <= TOL_W'(4))        n_c = 4'd2;
    else if (quo <= TOL_W'(8))   n_c = 4'd3;
    else if (quo <= TOL_W'(16))  n_c = 4'd4;
    else if (quo <= TOL_W'(32))  n_c = 4'd5;
    else if (quo <= TOL_W'(64))  n_c = 4'd6;
    else if (quo <= TOL_W'(128)) n_c = 4'd7;
    else                         n_c = 4'd8;
  end

  // The cosine step is a quarter turn ahead of the sine step.
  always_comb begin
    if (state == S_CMULX) begin
      step = 8'((i + 8'(nmask >> 2) + 8'd1) << sh);
    end else begin
      step = 8'(i << sh);
    end
  end

  assign div_start = (state == S_DECODE) && (req == REQ_CIRCLE);

  pps_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({rad, 2'b00}),
    .divisor  ((tol == '0) ? TOL_W'(1) : tol),
    .quotient (quo),
    .done     (div_done)
  );

  pps_scaler u_scl (
    .clk    (clk),
    .radius (rad),
    .step   (step),
    .prod   (prod)
  );

  assign req_stall = state != S_IDLE;

  // The tolerance register is to be written only while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_RESET;
    end else if (cfg_wen) begin
      tol <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cont      <= CONT_DONE;
      pc        <= '0;
      start     <= '0;
      sc        <= '0;
      res_valid <= 1'b0;
      dropped   <= 1'b0;
    end else begin
      // The result is raised as the sequencer finishes and dropped once taken.
      if (state == S_DONE && (!res_valid || !res_stall)) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            req     <= req_type;
            px      <= coord_x;
            py      <= coord_y;
            rad     <= circle_radius;
            idx     <= read_index;
            rpx     <= '0;
            rpy     <= '0;
            rend    <= '0;
            dropped <= 1'b0;
            cont    <= CONT_DONE;
            state   <= S_DECODE;
          end
        end
        S_DECODE: begin
          case (req)
            REQ_MOVE:   state <= S_MOVE;
            REQ_DRAW:   state <= S_DRAW;
            REQ_CLOSE:  state <= S_CLOSE;
            REQ_CIRCLE: state <= S_DIV;
            REQ_EMPTY: begin
              pc    <= '0;
              sc    <= '0;
              start <= '0;
              state <= S_DONE;
            end
            REQ_CURPT: begin
              px <= '0;
              py <= '0;
              state <= (pc == '0) ? S_MOVE : S_DONE;
            end
            default: state <= S_RPT;
          endcase
        end
        S_MOVE: begin
          if (len_one) begin
            lx    <= px;
            ly    <= py;
            state <= after_op;
          end else begin
            // Close the open subpath first, then draw the new start point.
            if (len_nz) begin
              if (!sfull) begin
                sc    <= sc + SCW'(1);
                start <= pc;
              end else begin
                dropped <= 1'b1;
              end
            end
            state <= S_DRAW;
          end
        end
        S_DRAW: begin
          if (!dup) begin
            if (pfull) begin
              dropped <= 1'b1;
            end else begin
              pc <= pc + PCW'(1);
              lx <= px;
              ly <= py;
            end
          end
          state <= after_op;
        end
        S_CLOSE: begin
          if (len_one) begin
            pc    <= pc - PCW'(1);
            state <= (pc != PCW'(1)) ? S_RLAST : S_DONE;
          end else begin
            if (len_nz) begin
              if (!sfull) begin
                sc    <= sc + SCW'(1);
                start <= pc;
              end else begin
                dropped <= 1'b1;
              end
            end
            state <= S_DONE;
          end
        end
        S_RLAST:  state <= S_RLAST2;
        S_RLAST2: begin
          lx    <= pm_rdata[2*COORD_W-1:COORD_W];
          ly    <= pm_rdata[COORD_W-1:0];
          state <= S_DONE;
        end
        S_RPT:    state <= S_RPT2;
        S_RPT2: begin
          if (req == REQ_RDPT && CW'(idx) < CW'(pc)) begin
            rpx <= pm_rdata[2*COORD_W-1:COORD_W];
            rpy <= pm_rdata[COORD_W-1:0];
          end
          if (req == REQ_RDEND && SW'(idx) < SW'(sc)) begin
            rend <= sm_rdata;
          end
          state <= S_DONE;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_CSET;
          end
        end
        S_CSET: begin
          cx    <= (pc != '0) ? lx : '0;
          cy    <= (pc != '0) ? ly : '0;
          px    <= ((pc != '0) ? lx : '0) + COORD_W'(rad);
          py    <= (pc != '0) ? ly : '0;
          nmask <= 8'((9'd1 << n_c) - 9'd1);
          sh    <= 4'd8 - n_c;
          i     <= '0;
          cont  <= CONT_LOOP;
          state <= S_MOVE;
        end
        S_CMULX:  state <= S_CMULY;
        S_CMULY: begin
          dx    <= scale_off(prod);
          state <= S_CPT;
        end
        S_CPT: begin
          px    <= cx + dx;
          py    <= cy + scale_off(prod);
          state <= S_DRAW;
        end
        S_CNEXT: begin
          if (i == nmask) begin
            cont  <= CONT_DONE;
            state <= S_CLOSE;
          end else begin
            i     <= i + 8'd1;
            state <= S_CMULX;
          end
        end
        S_DONE: begin
          if (!res_valid || !res_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result register, loaded as the sequencer leaves its final state.
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!res_valid || !res_stall)) begin
      status        <= dropped;
      last_x        <= (pc != '0) ? lx : '0;
      last_y        <= (pc != '0) ? ly : '0;
      point_total   <= 11'(pc);
      subpath_total <= 7'(sc);
      read_px       <= rpx;
      read_py       <= rpy;
      read_end      <= 11'(rend);
    end
  end

`ifndef ASSERT_OFF
  a_pc_bound: assert property (@(posedge clk) disable iff (rst)
    pc <= PCW'(POINT_DEPTH)) else $error("point count beyond store depth");
  a_sc_bound: assert property (@(posedge clk) disable iff (rst)
    sc <= SCW'(SUBPATH_DEPTH)) else $error("subpath count beyond depth");
  a_start: assert property (@(posedge clk) disable iff (rst)
    start <= pc) else $error("open subpath start beyond point count");
`endif

endmodule

// ===== tb/path_point_store_with_circle_tb.sv =====
// ----------------------------------------------------------------------------
// path_point_store_with_circle_tb: self-checking bench of the path point store
// A directed table and then random request streams are checked, field by
// field, against a behavioural model of the store, over several tolerance
// settings and idling phases on both channels.
// ----------------------------------------------------------------------------
module path_point_store_with_circle_tb;
  import pps_pkg::*;

  localparam int PDEPTH   = 1024;
  localparam int SDEPTH   = 64;
  localparam int WDOG_MAX = 20000;

  // One result as the block presents it.
  typedef struct packed {
    logic              status;
    logic [31:0]       lx;
    logic [31:0]       ly;
    logic [10:0]       pts;
    logic [6:0]        subs;
    logic [31:0]       rpx;
    logic [31:0]       rpy;
    logic [10:0]       rend;
  } path_result_t;

  // One row of the directed table. A row with has_fixed set also carries the
  // result that can be read straight off the behaviour.
  typedef struct {
    logic [2:0]   rq;
    logic [31:0]  x;
    logic [31:0]  y;
    logic [28:0]  rad;
    logic [9:0]   idx;
    bit           has_fixed;
    path_result_t fixed;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic [REQ_W-1:0] req_type = REQ_EMPTY;
  logic signed [COORD_W-1:0] coord_x = '0;
  logic signed [COORD_W-1:0] coord_y = '0;
  logic [RAD_W-1:0] circle_radius = '0;
  logic [IDX_W-1:0] read_index = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  logic status;
  logic signed [COORD_W-1:0] last_x, last_y, read_px, read_py;
  logic [10:0] point_total, read_end;
  logic [6:0] subpath_total;
  logic cfg_wen = 1'b0;
  logic [TOL_W-1:0] cfg_wdata = '0;

  always #4 clk = ~clk;

  path_point_store_with_circle i_dut (
    .clk, .rst, .req_valid, .req_stall, .req_type, .coord_x, .coord_y,
    .circle_radius, .read_index, .res_valid, .res_stall, .status, .last_x,
    .last_y, .point_total, .subpath_total, .read_px, .read_py, .read_end,
    .cfg_wen, .cfg_wdata
  );

  // Shadow copy of the block's state, kept by the path model below.
  logic [31:0] shadow_x [PDEPTH];
  logic [31:0] shadow_y [PDEPTH];
  logic [10:0] shadow_end [SDEPTH];
  int unsigned shadow_pts, shadow_subs;
  logic [30:0] shadow_tol;
  bit          shadow_drop;

  path_result_t pending_results[$];
  int  fail_count;
  int  send_idle_pct, recv_stall_pct;
  int  watchdog;

  // The open subpath runs from the last recorded end to the point count.
  function automatic int unsigned open_points();
    int unsigned start;
    start = (shadow_subs > 0) ? shadow_end[shadow_subs-1] : 0;
    return (shadow_pts >= start) ? shadow_pts - start : 0;
  endfunction

  function automatic void path_draw(logic [31:0] x, logic [31:0] y);
    if (open_points() > 0 && shadow_x[shadow_pts-1] == x && shadow_y[shadow_pts-1] == y)
      return;
    if (shadow_pts >= PDEPTH) begin
      shadow_drop = 1'b1;
      return;
    end
    shadow_x[shadow_pts] = x;
    shadow_y[shadow_pts] = y;
    shadow_pts++;
  endfunction

  function automatic void path_close();
    int unsigned len;
    len = open_points();
    if (len == 0) return;
    if (len == 1) begin
      shadow_pts--;
      return;
    end
    if (shadow_subs >= SDEPTH) begin
      shadow_drop = 1'b1;
      return;
    end
    shadow_end[shadow_subs] = shadow_pts[10:0];
    shadow_subs++;
  endfunction

  function automatic void path_move(logic [31:0] x, logic [31:0] y);
    int unsigned len;
    len = open_points();
    if (len == 1) begin
      shadow_x[shadow_pts-1] = x;
      shadow_y[shadow_pts-1] = y;
      return;
    end
    if (len > 1) path_close();
    path_draw(x, y);
  endfunction

  // Sine of step i out of 4*2^k per turn, 0x4000 being one.
  function automatic longint circle_sine(int unsigned i, int unsigned k);
    logic [7:0] e;
    longint v;
    logic [14:0] qs [65];
    qs = '{15'h0000, 15'h0192, 15'h0324, 15'h04b5, 15'h0646, 15'h07d6, 15'h0964,
           15'h0af1, 15'h0c7c, 15'h0e06, 15'h0f8d, 15'h1112, 15'h1294, 15'h1413,
           15'h1590, 15'h1709, 15'h187e, 15'h19ef, 15'h1b5d, 15'h1cc6, 15'h1e2b,
           15'h1f8c, 15'h20e7, 15'h223d, 15'h238e, 15'h24da, 15'h2620, 15'h2760,
           15'h289a, 15'h29ce, 15'h2afb, 15'h2c21, 15'h2d41, 15'h2e5a, 15'h2f6c,
           15'h3076, 15'h3179, 15'h3274, 15'h3368, 15'h3453, 15'h3537, 15'h3612,
           15'h36e5, 15'h37b0, 15'h3871, 15'h392b, 15'h39db, 15'h3a82, 15'h3b21,
           15'h3bb6, 15'h3c42, 15'h3cc5, 15'h3d3f, 15'h3daf, 15'h3e15, 15'h3e72,
           15'h3ec5, 15'h3f0f, 15'h3f4f, 15'h3f85, 15'h3fb1, 15'h3fd4, 15'h3fec,
           15'h3ffb, 15'h4000};
    e = 8'((i << (6 - k)) & 8'hff);
    v = e[6] ? longint'(qs[64 - e[5:0]]) : longint'(qs[e[5:0]]);
    return e[7] ? -v : v;
  endfunction

  // Round half up, then an arithmetic shift that floors.
  function automatic logic [31:0] circle_offset(logic [28:0] r, longint t);
    longint p;
    p = longint'(r) * t + 8192;
    return 32'(p >>> 14);
  endfunction

  function automatic void path_circle(logic [28:0] r);
    logic [31:0] tol, sides, cx, cy;
    int unsigned n, k;
    tol = (shadow_tol == 0) ? 32'd1 : {1'b0, shadow_tol};
    sides = (32'd4 * {3'b0, r}) / tol;
    if (sides > 256) sides = 256;
    n = 2;
    while ((32'd1 << n) < sides) n++;
    cx = 0;
    cy = 0;
    if (shadow_pts > 0) begin
      cx = shadow_x[shadow_pts-1];
      cy = shadow_y[shadow_pts-1];
    end
    path_move(cx + {3'b0, r}, cy);
    k = n - 2;
    for (int unsigned i = 1; i < (1 << n); i++)
      path_draw(cx + circle_offset(r, circle_sine(i + (64 >> (6 - k)), k)),
                cy + circle_offset(r, circle_sine(i, k)));
    path_close();
  endfunction

  // Applies one request to the shadow state and returns the result it causes.
  function automatic path_result_t path_apply(logic [2:0] rq, logic [31:0] x,
                                              logic [31:0] y, logic [28:0] r,
                                              logic [9:0] idx);
    path_result_t res;
    res = '0;
    shadow_drop = 1'b0;
    case (rq)
      REQ_MOVE:   path_move(x, y);
      REQ_DRAW:   path_draw(x, y);
      REQ_CLOSE:  path_close();
      REQ_CIRCLE: path_circle(r);
      REQ_EMPTY: begin
        shadow_pts = 0;
        shadow_subs = 0;
      end
      REQ_CURPT:  if (shadow_pts == 0) path_move(0, 0);
      REQ_RDPT: begin
        if (idx < shadow_pts) begin
          res.rpx = shadow_x[idx];
          res.rpy = shadow_y[idx];
        end
      end
      default:    if (idx < shadow_subs) res.rend = shadow_end[idx];
    endcase
    if (shadow_pts > 0) begin
      res.lx = shadow_x[shadow_pts-1];
      res.ly = shadow_y[shadow_pts-1];
    end
    res.status = shadow_drop;
    res.pts = shadow_pts[10:0];
    res.subs = shadow_subs[6:0];
    return res;
  endfunction

  // The model's current view, as a read of nothing would report it.
  function automatic path_result_t path_apply_peek();
    path_result_t res;
    res = '0;
    if (shadow_pts > 0) begin
      res.lx = shadow_x[shadow_pts-1];
      res.ly = shadow_y[shadow_pts-1];
    end
    res.pts = shadow_pts[10:0];
    res.subs = shadow_subs[6:0];
    return res;
  endfunction

  // Drives one request and holds it until the transfer happens. The valid is
  // only lowered when a sender gap follows, so it never toggles in one step.
  task automatic send_request(logic [2:0] rq, logic [31:0] x, logic [31:0] y,
                              logic [28:0] r, logic [9:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_type <= rq;
    coord_x <= x;
    coord_y <= y;
    circle_radius <= r;
    read_index <= idx;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // Waits until every expected result has arrived, then lets the block settle.
  task automatic drain_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Tolerance writes happen only while the block is idle.
  task automatic write_tolerance(logic [30:0] v);
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    shadow_tol = v;
    @(posedge clk);
  endtask

  // Random coordinates: mostly small values, now and then the full range.
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(64)) - 32) << 16;
      default: return 32'($urandom_range(2000));
    endcase
  endfunction

  // Radii that give every side count, plus the occasional full-range value.
  function automatic logic [28:0] rand_radius();
    if ($urandom_range(15) == 0) return 29'($urandom);
    return 29'((longint'(shadow_tol) * $urandom_range(260)) / 4 + $urandom_range(3));
  endfunction

  // The point the model last stored, for a draw that repeats it.
  function automatic logic [31:0] last_sent_x();
    return (shadow_pts > 0) ? shadow_x[shadow_pts-1] : 32'd0;
  endfunction
  function automatic logic [31:0] last_sent_y();
    return (shadow_pts > 0) ? shadow_y[shadow_pts-1] : 32'd0;
  endfunction

  // Mostly well-formed subpaths (move, some draws, close) and circles, with
  // reads, queries, empties and stray requests mixed in as noise.
  task automatic random_phase(int items);
    int sent;
    int unsigned draws;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: begin
          send_request(REQ_MOVE, rand_coord(), rand_coord(), 29'd0, 10'($urandom));
          draws = $urandom_range(12);
          for (int unsigned d = 0; d < draws; d++)
            send_request(REQ_DRAW, rand_coord(), rand_coord(), 29'($urandom),
                         10'($urandom));
          if ($urandom_range(4) == 0)
            send_request(REQ_DRAW, last_sent_x(), last_sent_y(), 29'd0, 10'd0);
          send_request(REQ_CLOSE, $urandom, $urandom, 29'($urandom), 10'($urandom));
          sent += draws + 2;
        end
        5: begin
          send_request(REQ_CIRCLE, rand_coord(), rand_coord(), rand_radius(),
                       10'($urandom));
          sent++;
        end
        6: begin
          send_request(REQ_RDPT, $urandom, $urandom, 29'($urandom),
                       10'($urandom_range(shadow_pts + 3)));
          send_request(REQ_RDEND, $urandom, $urandom, 29'($urandom),
                       10'($urandom_range(shadow_subs + 3)));
          sent += 2;
        end
        7: begin
          send_request(REQ_RDPT, $urandom, $urandom, 29'($urandom), 10'($urandom));
          send_request(REQ_RDEND, $urandom, $urandom, 29'($urandom), 10'($urandom));
          sent += 2;
        end
        8: begin
          send_request(3'($urandom_range(7)), rand_coord(), rand_coord(),
                       29'($urandom_range(300000)), 10'($urandom));
          sent++;
        end
        default: begin
          if ($urandom_range(2) == 0)
            send_request(REQ_EMPTY, $urandom, $urandom, 29'd0, 10'd0);
          else
            send_request(REQ_CURPT, $urandom, $urandom, 29'($urandom), 10'($urandom));
          sent++;
        end
      endcase
    end
  endtask

  // Every accepted request is applied to the model at the transfer edge, so
  // the model always sees the requests in the order the block takes them.
  always @(posedge clk) begin
    if (!rst && req_valid && !req_stall)
      pending_results.push_back(path_apply(req_type, coord_x, coord_y,
                                           circle_radius, read_index));
  end

  // Results are compared with the oldest expectation on each transfer.
  always @(posedge clk) begin
    path_result_t got, want;
    if (!rst && res_valid && !res_stall) begin
      got = '{status, last_x, last_y, point_total, subpath_total, read_px, read_py,
              read_end};
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request outstanding: %p", $time, got);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected %p actual %p", $time, want, got);
          fail_count++;
        end
      end
    end
  end

  // The receiver stalls at random according to the current phase.
  always @(posedge clk)
    res_stall <= ($urandom_range(99) < recv_stall_pct);

  // A cycle with no transfer on either channel and no tolerance write counts towards the limit.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (res_valid && !res_stall) || cfg_wen)
      watchdog <= 0;
    else
      watchdog <= watchdog + 1;
    if (watchdog >= WDOG_MAX) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    dir_row_t table_rows [$];
    path_result_t seen;
    int tol_phase;
    logic [30:0] tol_set [4];
    fail_count = 0;
    watchdog = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    shadow_pts = 0;
    shadow_subs = 0;
    shadow_tol = TOL_RESET;
    tol_set = '{31'd16384, 31'd1, 31'h7fffffff, 31'd0};

    // Directed table. Fixed results are given for rows whose answer is plain.
    table_rows = '{
      '{REQ_RDPT,   0, 0, 0, 0,      1, '{0, 0, 0, 0, 0, 0, 0, 0}},
      '{REQ_RDEND,  0, 0, 0, 10'h3ff, 1, '{0, 0, 0, 0, 0, 0, 0, 0}},
      '{REQ_CLOSE,  0, 0, 0, 0,      1, '{0, 0, 0, 0, 0, 0, 0, 0}},
      '{REQ_CURPT,  5, 5, 0, 0,      1, '{0, 0, 0, 1, 0, 0, 0, 0}},
      '{REQ_MOVE,   32'h7fffffff, 32'h80000000, 0, 0, 1,
        '{0, 32'h7fffffff, 32'h80000000, 1, 0, 0, 0, 0}},
      '{REQ_DRAW,   32'h7fffffff, 32'h80000000, 0, 0, 1,
        '{0, 32'h7fffffff, 32'h80000000, 1, 0, 0, 0, 0}},
      '{REQ_DRAW,   32'h80000000, 32'h7fffffff, 0, 0, 0, '{default: 0}},
      '{REQ_DRAW,   32'hffffffff, 32'h0, 0, 0, 0, '{default: 0}},
      '{REQ_RDPT,   0, 0, 0, 1,      0, '{default: 0}},
      '{REQ_CLOSE,  0, 0, 0, 0,      0, '{default: 0}},
      '{REQ_RDEND,  0, 0, 0, 0,      0, '{default: 0}},
      '{REQ_MOVE,   1, 2, 0, 0,      0, '{default: 0}},
      '{REQ_MOVE,   3, 4, 0, 0,      0, '{default: 0}},
      '{REQ_CLOSE,  0, 0, 0, 0,      0, '{default: 0}},
      '{REQ_CIRCLE, 0, 0, 29'h10000, 0, 0, '{default: 0}},
      '{REQ_CIRCLE, 0, 0, 29'h1fffffff, 0, 0, '{default: 0}},
      '{REQ_CIRCLE, 0, 0, 0, 0,      0, '{default: 0}},
      '{REQ_RDPT,   0, 0, 0, 10'h3ff, 0, '{default: 0}},
      '{REQ_RDEND,  0, 0, 0, 1,      0, '{default: 0}},
      '{REQ_EMPTY,  0, 0, 0, 0,      1, '{0, 0, 0, 0, 0, 0, 0, 0}},
      '{REQ_RDPT,   0, 0, 0, 0,      1, '{0, 0, 0, 0, 0, 0, 0, 0}}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (table_rows[r]) begin
      send_request(table_rows[r].rq, table_rows[r].x, table_rows[r].y,
                   table_rows[r].rad, table_rows[r].idx);
      if (table_rows[r].has_fixed) begin
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        seen = pending_results.size() == 0 ? table_rows[r].fixed : '0;
        // The model must agree with the plain answer; the block was checked
        // against the model as the result went by.
        if (path_apply_peek() !== seen) begin
          $display("%0t: table row %0d expected %p actual %p", $time, r, seen,
                   path_apply_peek());
          fail_count++;
        end
      end
    end
    drain_results();

    // Fill the stores to the brim so that dropped writes are seen.
    write_tolerance(31'd1);
    for (int c = 0; c < 6; c++)
      send_request(REQ_CIRCLE, 0, 0, 29'd64 + 29'(c), 0);
    for (int s = 0; s < 70; s++) begin
      send_request(REQ_MOVE, 32'(s), 0, 0, 0);
      send_request(REQ_DRAW, 32'(s), 1, 0, 0);
      send_request(REQ_CLOSE, 0, 0, 0, 0);
    end
    send_request(REQ_RDPT, 0, 0, 0, 10'h3ff);
    send_request(REQ_RDEND, 0, 0, 0, 10'd63);
    send_request(REQ_EMPTY, 0, 0, 0, 0);
    drain_results();

    // Random phases, each idling pattern under each tolerance setting.
    for (tol_phase = 0; tol_phase < 4; tol_phase++) begin
      write_tolerance(tol_set[tol_phase]);
      for (int ph = 0; ph < 4; ph++) begin
        send_idle_pct  = (ph == 1) ? 66 : (ph == 3) ? 24 : 0;
        recv_stall_pct = (ph == 2) ? 66 : (ph == 3) ? 24 : 0;
        random_phase(85);
        if (ph == 1) drain_results();
      end
      drain_results();
    end
    write_tolerance(31'($urandom));
    random_phase(50);
    drain_results();

    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/pps_pkg.sv
hdl/pps_divider.sv
hdl/pps_scaler.sv
hdl/path_point_store_with_circle.sv
tb/path_point_store_with_circle_tb.sv
